// ===== hw/rtl/tagged_packet_queue_pair_macros.svh =====
// assertion macros for the tagged packet queue pair
// used by the top level; no other dependencies
`ifndef TAGGED_PACKET_QUEUE_PAIR_MACROS_SVH
`define TAGGED_PACKET_QUEUE_PAIR_MACROS_SVH

// same-cycle implication, disabled during reset
`define TPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define TPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tpq_pkg.sv =====
// command codes and fixed port widths for the tagged packet queue pair
// no dependencies
package tpq_pkg;

   typedef enum logic [1:0] {
      CMD_ADD        = 2'd0,
      CMD_GET        = 2'd1,
      CMD_FLUSH_CONN = 2'd2,
      CMD_FLUSH_ALL  = 2'd3
   } cmd_type;

   localparam int unsigned ID_PORT_BITS     = 8;
   localparam int unsigned HANDLE_PORT_BITS = 8;
   localparam int unsigned REMOVED_BITS     = 6;
   localparam int unsigned OCC_BITS         = 5;

endpackage

// ===== hw/rtl/tpq_store.sv =====
// entry store for both queues: one write port, one read port, registered read
// no dependencies
module tpq_store #(
   parameter int unsigned ADDR_BITS = 5,
   parameter int unsigned DATA_BITS = 16
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem_ff [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tagged_packet_queue_pair.sv =====
// tagged packet queue pair: add and flush all go straight to finish, result registered
// get scans the selected queue from the head to the first tag match, or all on a miss
// flush by connection scans both queues, queue 0 then queue 1; one entry per cycle
// one item at a time, next item accepted as its result shows; receiver cannot stall
// synchronous active-high reset empties both queues; entry store contents are not cleared
// depends on tpq_pkg, tpq_store and tagged_packet_queue_pair_macros.svh
`include "tagged_packet_queue_pair_macros.svh"

module tagged_packet_queue_pair #(
   parameter int unsigned QUEUE_DEPTH = 16,
   parameter int unsigned TAG_BITS    = 8,
   parameter int unsigned HANDLE_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_cmd,
   input  logic                                   req_queue_sel,
   input  logic [tpq_pkg::ID_PORT_BITS-1:0]       req_conn_id,
   input  logic [tpq_pkg::HANDLE_PORT_BITS-1:0]   req_packet_handle,
   output logic                                   rsp_valid,
   output logic [tpq_pkg::HANDLE_PORT_BITS-1:0]   rsp_out_handle,
   output logic                                   rsp_found,
   output logic                                   rsp_dropped,
   output logic [tpq_pkg::REMOVED_BITS-1:0]       rsp_removed_count,
   output logic [tpq_pkg::OCC_BITS-1:0]           rsp_occupancy
);

   localparam int unsigned PW = $clog2(QUEUE_DEPTH);
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned SW = CW + 1;
   localparam int unsigned RW = CW + 1;
   localparam int unsigned EW = TAG_BITS + HANDLE_BITS;
   localparam int unsigned AW = PW + 1;
   localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] h, input logic [CW-1:0] c);
      logic [SW-1:0] s;
      s = SW'(h) + SW'(c);
      if (s >= SW'(QUEUE_DEPTH)) begin
         s = s - SW'(QUEUE_DEPTH);
      end
      return s[PW-1:0];
   endfunction

   state_type            state_ff;
   tpq_pkg::cmd_type     cmd_ff;
   logic                 sel_ff;
   logic                 q_ff;
   logic [TAG_BITS-1:0]  tag_ff;
   logic [PW-1:0]        head_ff [2];
   logic [CW-1:0]        count_ff [2];
   logic [PW-1:0]        rd_ptr_ff;
   logic [PW-1:0]        wr_ptr_ff;
   logic [PW-1:0]        pos_ff;
   logic [CW-1:0]        n_ff;
   logic [CW-1:0]        issued_ff;
   logic [CW-1:0]        kept_ff;
   logic                 pend_ff;
   logic [RW-1:0]        removed_ff;
   logic                 found_ff;
   logic                 dropped_ff;
   logic [HANDLE_BITS-1:0] res_handle_ff;

   logic                 rsp_valid_ff;
   logic [tpq_pkg::HANDLE_PORT_BITS-1:0] rsp_out_handle_ff;
   logic                 rsp_found_ff;
   logic                 rsp_dropped_ff;
   logic [tpq_pkg::REMOVED_BITS-1:0] rsp_removed_count_ff;
   logic [tpq_pkg::OCC_BITS-1:0] rsp_occupancy_ff;

   logic                 accept;
   tpq_pkg::cmd_type     req_cmd_in;
   logic [TAG_BITS+tpq_pkg::ID_PORT_BITS-1:0] tag_wide;
   logic [HANDLE_BITS+tpq_pkg::HANDLE_PORT_BITS-1:0] handle_wide;
   logic [TAG_BITS-1:0]  tag_in;
   logic [HANDLE_BITS-1:0] handle_in;
   logic                 sel_full;
   logic [PW-1:0]        add_ptr;
   logic                 issue;
   logic                 match;
   logic                 scan_wr;
   logic                 scan_end;
   logic [TAG_BITS-1:0]  rd_tag;
   logic [HANDLE_BITS-1:0] rd_handle;
   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [EW-1:0]        mem_wr_data;
   logic [AW-1:0]        mem_rd_addr;
   logic [EW-1:0]        mem_rd_data;
   logic [HANDLE_BITS+tpq_pkg::HANDLE_PORT_BITS-1:0] out_handle_wide;
   logic [RW+tpq_pkg::REMOVED_BITS-1:0] removed_wide;
   logic [CW+tpq_pkg::OCC_BITS-1:0] occ_wide;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign req_cmd_in = tpq_pkg::cmd_type'(req_cmd);

   assign tag_wide    = {{TAG_BITS{1'b0}}, req_conn_id};
   assign tag_in      = tag_wide[TAG_BITS-1:0];
   assign handle_wide = {{HANDLE_BITS{1'b0}}, req_packet_handle};
   assign handle_in   = handle_wide[HANDLE_BITS-1:0];
   assign sel_full    = (count_ff[req_queue_sel] >= FULL_COUNT);
   assign add_ptr     = ptr_add(head_ff[req_queue_sel], count_ff[req_queue_sel]);

   assign rd_tag    = mem_rd_data[EW-1:HANDLE_BITS];
   assign rd_handle = mem_rd_data[HANDLE_BITS-1:0];
   assign issue     = (state_ff == ST_SCAN) && (issued_ff < n_ff);
   assign match     = (state_ff == ST_SCAN) && pend_ff && (rd_tag == tag_ff);
   assign scan_wr   = (state_ff == ST_SCAN) && pend_ff && !match;
   assign scan_end  = (state_ff == ST_SCAN) && !pend_ff && (issued_ff == n_ff);

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = {q_ff, wr_ptr_ff};
      mem_wr_data = mem_rd_data;
      mem_rd_addr = {q_ff, rd_ptr_ff};
      if (accept && (req_cmd_in == tpq_pkg::CMD_ADD) && !sel_full) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = {req_queue_sel, add_ptr};
         mem_wr_data = {tag_in, handle_in};
      end else if (scan_wr) begin
         mem_wr_en = 1'b1;
      end
   end

   tpq_store #(
      .ADDR_BITS (AW),
      .DATA_BITS (EW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign out_handle_wide = {{tpq_pkg::HANDLE_PORT_BITS{1'b0}}, res_handle_ff};
   assign removed_wide    = {{tpq_pkg::REMOVED_BITS{1'b0}}, removed_ff};
   assign occ_wide        = {{tpq_pkg::OCC_BITS{1'b0}}, count_ff[sel_ff]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         head_ff[0]   <= '0;
         head_ff[1]   <= '0;
         count_ff[0]  <= '0;
         count_ff[1]  <= '0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_FINISH);
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cmd_ff        <= req_cmd_in;
                  sel_ff        <= req_queue_sel;
                  tag_ff        <= tag_in;
                  found_ff      <= 1'b0;
                  dropped_ff    <= 1'b0;
                  removed_ff    <= '0;
                  res_handle_ff <= '0;
                  issued_ff     <= '0;
                  kept_ff       <= '0;
                  pend_ff       <= 1'b0;
                  unique case (req_cmd_in)
                     tpq_pkg::CMD_ADD: begin
                        if (sel_full) begin
                           dropped_ff    <= 1'b1;
                           res_handle_ff <= handle_in;
                        end else begin
                           count_ff[req_queue_sel] <= count_ff[req_queue_sel] + 1'b1;
                        end
                        state_ff <= ST_FINISH;
                     end
                     tpq_pkg::CMD_GET: begin
                        q_ff      <= req_queue_sel;
                        rd_ptr_ff <= head_ff[req_queue_sel];
                        wr_ptr_ff <= add_ptr;
                        n_ff      <= count_ff[req_queue_sel];
                        state_ff  <= ST_SCAN;
                     end
                     tpq_pkg::CMD_FLUSH_CONN: begin
                        q_ff      <= 1'b0;
                        rd_ptr_ff <= head_ff[0];
                        wr_ptr_ff <= ptr_add(head_ff[0], count_ff[0]);
                        n_ff      <= count_ff[0];
                        state_ff  <= ST_SCAN;
                     end
                     tpq_pkg::CMD_FLUSH_ALL: begin
                        removed_ff  <= RW'(count_ff[0]) + RW'(count_ff[1]);
                        count_ff[0] <= '0;
                        count_ff[1] <= '0;
                        state_ff    <= ST_FINISH;
                     end
                     default: begin
                        state_ff <= ST_FINISH;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               pend_ff <= issue;
               if (issue) begin
                  rd_ptr_ff <= ptr_inc(rd_ptr_ff);
                  pos_ff    <= ptr_inc(rd_ptr_ff);
                  issued_ff <= issued_ff + 1'b1;
               end
               if (scan_wr) begin
                  wr_ptr_ff <= ptr_inc(wr_ptr_ff);
                  kept_ff   <= kept_ff + 1'b1;
               end
               if (match && (cmd_ff == tpq_pkg::CMD_GET)) begin
                  found_ff       <= 1'b1;
                  res_handle_ff  <= rd_handle;
                  head_ff[q_ff]  <= pos_ff;
                  count_ff[q_ff] <= n_ff - 1'b1;
                  state_ff       <= ST_FINISH;
               end else if (scan_end) begin
                  head_ff[q_ff]  <= rd_ptr_ff;
                  count_ff[q_ff] <= kept_ff;
                  if (cmd_ff == tpq_pkg::CMD_FLUSH_CONN) begin
                     removed_ff <= removed_ff + RW'(n_ff - kept_ff);
                  end
                  if ((cmd_ff == tpq_pkg::CMD_FLUSH_CONN) && !q_ff) begin
                     q_ff      <= 1'b1;
                     rd_ptr_ff <= head_ff[1];
                     wr_ptr_ff <= ptr_add(head_ff[1], count_ff[1]);
                     n_ff      <= count_ff[1];
                     issued_ff <= '0;
                     kept_ff   <= '0;
                  end else begin
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_FINISH: begin
               rsp_out_handle_ff    <= out_handle_wide[tpq_pkg::HANDLE_PORT_BITS-1:0];
               rsp_found_ff         <= found_ff;
               rsp_dropped_ff       <= dropped_ff;
               rsp_removed_count_ff <= removed_wide[tpq_pkg::REMOVED_BITS-1:0];
               rsp_occupancy_ff     <= occ_wide[tpq_pkg::OCC_BITS-1:0];
               state_ff             <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_handle    = rsp_out_handle_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_dropped       = rsp_dropped_ff;
   assign rsp_removed_count = rsp_removed_count_ff;
   assign rsp_occupancy     = rsp_occupancy_ff;

   `TPQ_ASSERT_NOW(a_rsp_when_idle, clock, reset, rsp_valid_ff, state_ff == ST_IDLE,
                   "result strobe outside idle")
   `TPQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
                   (count_ff[0] <= FULL_COUNT) && (count_ff[1] <= FULL_COUNT),
                   "queue count above depth")
   `TPQ_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy,
                    "not busy after accepting an item")
   `TPQ_ASSERT_NOW(a_scan_counts, clock, reset, state_ff == ST_SCAN,
                   (kept_ff <= issued_ff) && (issued_ff <= n_ff), "scan counters out of order")
   `TPQ_ASSERT_NOW(a_found_dropped, clock, reset, rsp_valid_ff,
                   !(rsp_found_ff && rsp_dropped_ff), "found and dropped together")

endmodule

// ===== test/tb_tagged_packet_queue_pair.sv =====
// testbench for tagged_packet_queue_pair: directed and random command traffic on
// both queues, every result checked against an in-bench queue predictor
// depends on tpq_pkg and the tagged_packet_queue_pair rtl
`timescale 1ns / 1ps

module tb_tagged_packet_queue_pair;

   localparam int QUEUE_DEPTH      = 16;
   localparam int RANDOM_ITEMS     = 1600;
   localparam int SETTLE_CYCLES    = 40;
   localparam int ID_PORT_BITS     = tpq_pkg::ID_PORT_BITS;
   localparam int HANDLE_PORT_BITS = tpq_pkg::HANDLE_PORT_BITS;
   localparam int REMOVED_BITS     = tpq_pkg::REMOVED_BITS;
   localparam int OCC_BITS         = tpq_pkg::OCC_BITS;

   typedef struct packed {
      logic [ID_PORT_BITS-1:0]     tag;
      logic [HANDLE_PORT_BITS-1:0] handle;
   } queue_entry_type;

   typedef struct packed {
      logic [HANDLE_PORT_BITS-1:0] out_handle;
      logic                        found;
      logic                        dropped;
      logic [REMOVED_BITS-1:0]     removed_count;
      logic [OCC_BITS-1:0]         occupancy;
   } response_type;

   logic                        clock;
   logic                        reset             = 1'b1;
   logic                        start             = 1'b0;
   logic                        busy;
   logic [1:0]                  req_cmd           = '0;
   logic                        req_queue_sel     = 1'b0;
   logic [ID_PORT_BITS-1:0]     req_conn_id       = '0;
   logic [HANDLE_PORT_BITS-1:0] req_packet_handle = '0;
   logic                        rsp_valid;
   logic [HANDLE_PORT_BITS-1:0] rsp_out_handle;
   logic                        rsp_found;
   logic                        rsp_dropped;
   logic [REMOVED_BITS-1:0]     rsp_removed_count;
   logic [OCC_BITS-1:0]         rsp_occupancy;

   queue_entry_type model_queue [2][$];
   response_type    pending_responses [$];

   int  items_sent      = 0;
   int  responses_seen  = 0;
   int  mismatch_count  = 0;
   int  adds_dropped    = 0;
   int  gets_hit        = 0;
   int  gets_missed     = 0;
   int  flushes         = 0;
   int  entries_flushed = 0;
   int  full_flush_alls = 0;
   bit  gaps_enabled    = 1'b1;

   tagged_packet_queue_pair i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_queue_sel     (req_queue_sel),
      .req_conn_id       (req_conn_id),
      .req_packet_handle (req_packet_handle),
      .rsp_valid         (rsp_valid),
      .rsp_out_handle    (rsp_out_handle),
      .rsp_found         (rsp_found),
      .rsp_dropped       (rsp_dropped),
      .rsp_removed_count (rsp_removed_count),
      .rsp_occupancy     (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      if (mismatch_count < 40)
         $display("result %0d: %s got %0d expected %0d", responses_seen, what, got, want);
      mismatch_count++;
   endtask

   function automatic int flush_matching(int q, logic [ID_PORT_BITS-1:0] tag);
      int              n;
      int              removed;
      queue_entry_type e;
      n       = model_queue[q].size();
      removed = 0;
      for (int i = 0; i < n; i++) begin
         e = model_queue[q].pop_front();
         if (e.tag == tag) removed++;
         else model_queue[q].push_back(e);
      end
      return removed;
   endfunction

   function automatic response_type apply_queue_command(tpq_pkg::cmd_type cmd, logic sel,
                                                        logic [ID_PORT_BITS-1:0] conn,
                                                        logic [HANDLE_PORT_BITS-1:0] handle);
      response_type    r;
      queue_entry_type e;
      int              q;
      int              n;
      r = '0;
      q = int'(sel);
      case (cmd)
         tpq_pkg::CMD_ADD: begin
            if (model_queue[q].size() >= QUEUE_DEPTH) begin
               r.dropped    = 1'b1;
               r.out_handle = handle;
            end else begin
               e.tag    = conn;
               e.handle = handle;
               model_queue[q].push_back(e);
            end
         end
         tpq_pkg::CMD_GET: begin
            n = model_queue[q].size();
            for (int i = 0; i < n; i++) begin
               e = model_queue[q].pop_front();
               if (e.tag == conn) begin
                  r.found      = 1'b1;
                  r.out_handle = e.handle;
                  break;
               end
               model_queue[q].push_back(e);
            end
         end
         tpq_pkg::CMD_FLUSH_CONN: begin
            r.removed_count = REMOVED_BITS'(flush_matching(0, conn) + flush_matching(1, conn));
         end
         default: begin
            r.removed_count = REMOVED_BITS'(model_queue[0].size() + model_queue[1].size());
            model_queue[0].delete();
            model_queue[1].delete();
         end
      endcase
      r.occupancy = OCC_BITS'(model_queue[q].size());
      return r;
   endfunction

   task automatic idle_sender(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_for_all_responses();
      start <= 1'b0;
      do @(posedge clock); while (pending_responses.size() != 0);
   endtask

   task automatic send_item(tpq_pkg::cmd_type cmd, logic sel, logic [ID_PORT_BITS-1:0] conn,
                            logic [HANDLE_PORT_BITS-1:0] handle);
      response_type r;
      if (gaps_enabled && $urandom_range(99) < 10) idle_sender($urandom_range(1, 4));
      req_cmd           <= cmd;
      req_queue_sel     <= sel;
      req_conn_id       <= conn;
      req_packet_handle <= handle;
      start             <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      r = apply_queue_command(cmd, sel, conn, handle);
      pending_responses.push_back(r);
      items_sent++;
      if (r.dropped) adds_dropped++;
      if (cmd == tpq_pkg::CMD_GET) begin
         if (r.found) gets_hit++;
         else gets_missed++;
      end
      if (cmd == tpq_pkg::CMD_FLUSH_CONN || cmd == tpq_pkg::CMD_FLUSH_ALL) begin
         flushes++;
         entries_flushed += r.removed_count;
      end
      if (cmd == tpq_pkg::CMD_FLUSH_ALL && r.removed_count == 2 * QUEUE_DEPTH)
         full_flush_alls++;
   endtask

   always @(posedge clock) begin : check_responses
      response_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("strobe with nothing pending", 1, 0);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_out_handle !== want.out_handle)
               report_mismatch("out_handle", rsp_out_handle, want.out_handle);
            if (rsp_found !== want.found)
               report_mismatch("found", rsp_found, want.found);
            if (rsp_dropped !== want.dropped)
               report_mismatch("dropped", rsp_dropped, want.dropped);
            if (rsp_removed_count !== want.removed_count)
               report_mismatch("removed_count", rsp_removed_count, want.removed_count);
            if (rsp_occupancy !== want.occupancy)
               report_mismatch("occupancy", rsp_occupancy, want.occupancy);
         end
         responses_seen++;
      end
   end

   function automatic logic [ID_PORT_BITS-1:0] pick_conn_id(int q);
      logic [ID_PORT_BITS-1:0] common_ids [4];
      int                      r;
      common_ids = '{8'h00, 8'h01, 8'h80, 8'hff};
      r = $urandom_range(99);
      if (r < 50 && model_queue[q].size() != 0)
         return model_queue[q][$urandom_range(model_queue[q].size() - 1)].tag;
      if (r < 85) return common_ids[$urandom_range(3)];
      return ID_PORT_BITS'($urandom_range(255));
   endfunction

   task automatic test_add_and_get();
      send_item(tpq_pkg::CMD_GET, 1'b1, 8'h00, 8'h00);
      send_item(tpq_pkg::CMD_ADD, 1'b1, 8'h00, 8'hff);
      send_item(tpq_pkg::CMD_ADD, 1'b1, 8'hff, 8'h00);
      send_item(tpq_pkg::CMD_ADD, 1'b1, 8'h11, 8'h22);
      // match behind two others: both rotate to the tail
      send_item(tpq_pkg::CMD_GET, 1'b1, 8'h11, 8'h00);
      send_item(tpq_pkg::CMD_GET, 1'b1, 8'h77, 8'h00);
      send_item(tpq_pkg::CMD_GET, 1'b1, 8'hff, 8'h00);
   endtask

   task automatic test_full_queue_drop();
      for (int i = 0; i < QUEUE_DEPTH; i++)
         send_item(tpq_pkg::CMD_ADD, 1'b0, (i % 2 == 0) ? 8'h01 : 8'h02,
                   HANDLE_PORT_BITS'(i * 17));
      send_item(tpq_pkg::CMD_ADD, 1'b0, 8'hff, 8'hff);
   endtask

   task automatic test_flush_by_connection();
      send_item(tpq_pkg::CMD_FLUSH_CONN, 1'b0, 8'h01, 8'h00);
   endtask

   task automatic test_flush_all();
      send_item(tpq_pkg::CMD_FLUSH_ALL, 1'b1, 8'h00, 8'h00);
   endtask

   task automatic test_random_traffic();
      int   pick;
      logic sel;
      while (items_sent < RANDOM_ITEMS) begin
         gaps_enabled = !(items_sent >= 700 && items_sent < 1000);
         pick = $urandom_range(99);
         sel  = 1'($urandom_range(1));
         if (pick < 35) begin
            repeat ($urandom_range(1, 20))
               send_item(tpq_pkg::CMD_ADD, sel, pick_conn_id(sel),
                         HANDLE_PORT_BITS'($urandom_range(255)));
         end else if (pick < 60) begin
            repeat ($urandom_range(1, 6))
               send_item(tpq_pkg::CMD_GET, sel, pick_conn_id(sel),
                         HANDLE_PORT_BITS'($urandom_range(255)));
         end else if (pick < 75) begin
            send_item(tpq_pkg::CMD_FLUSH_CONN, sel, pick_conn_id($urandom_range(1)),
                      HANDLE_PORT_BITS'($urandom_range(255)));
         end else if (pick < 79) begin
            send_item(tpq_pkg::CMD_FLUSH_ALL, sel, ID_PORT_BITS'($urandom_range(255)),
                      HANDLE_PORT_BITS'($urandom_range(255)));
         end else if (pick < 83) begin
            // both queues full, a drop, then flush all
            while (model_queue[0].size() < QUEUE_DEPTH)
               send_item(tpq_pkg::CMD_ADD, 1'b0, pick_conn_id(0),
                         HANDLE_PORT_BITS'($urandom_range(255)));
            while (model_queue[1].size() < QUEUE_DEPTH)
               send_item(tpq_pkg::CMD_ADD, 1'b1, pick_conn_id(1),
                         HANDLE_PORT_BITS'($urandom_range(255)));
            send_item(tpq_pkg::CMD_ADD, sel, ID_PORT_BITS'($urandom_range(255)),
                      HANDLE_PORT_BITS'($urandom_range(255)));
            send_item(tpq_pkg::CMD_FLUSH_ALL, sel, ID_PORT_BITS'($urandom_range(255)),
                      HANDLE_PORT_BITS'($urandom_range(255)));
         end else if (pick < 85) begin
            wait_for_all_responses();
         end else begin
            repeat ($urandom_range(1, 8))
               send_item(tpq_pkg::cmd_type'($urandom_range(3)), 1'($urandom_range(1)),
                         ID_PORT_BITS'($urandom_range(255)),
                         HANDLE_PORT_BITS'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      int settle;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_add_and_get();
      test_full_queue_drop();
      test_flush_by_connection();
      test_flush_all();
      wait_for_all_responses();
      test_random_traffic();

      start <= 1'b0;
      settle = 0;
      while (pending_responses.size() != 0 && settle < 2000) begin
         @(posedge clock);
         settle++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_responses.size() != 0)
         report_mismatch("results never returned", 0, pending_responses.size());

      $display("covered %0d items: %0d gets hit, %0d missed, %0d adds dropped on a full queue",
               items_sent, gets_hit, gets_missed, adds_dropped);
      $display("%0d flushes removed %0d entries, %0d of them flush all with both queues full",
               flushes, entries_flushed, full_flush_alls);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tpq_pkg.sv
hw/rtl/tpq_store.sv
hw/rtl/tagged_packet_queue_pair.sv
test/tb_tagged_packet_queue_pair.sv
